[rtl/core/collatz_stopping_time_histogram_defines.svh]
`ifndef COLLATZ_STOPPING_TIME_HISTOGRAM_DEFINES_SVH
`define COLLATZ_STOPPING_TIME_HISTOGRAM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSTH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CSTH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/csth_pkg.sv]
`default_nettype none

package csth_pkg;

	localparam int unsigned TOP_BIN    = 1000;
	localparam int unsigned HIST_DEPTH = TOP_BIN + 1;
	localparam int unsigned BIN_W      = 10;
	localparam int unsigned STEP_W     = 16;
	localparam int unsigned CNT_W      = 64;
	localparam int unsigned START_W    = 64;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned S_DATA_W   = 80;
	localparam int unsigned M_DATA_W   = 96;

	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [BIN_W-1:0]  BIN_TOP  = BIN_W'(TOP_BIN);

	typedef enum logic [CMD_W-1:0] {
		CMD_PROC  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ITER,
		ST_READ,
		ST_UPDATE,
		ST_DONE
	} state_t;

	function automatic logic [BIN_W-1:0] clamp_bin(input logic [STEP_W-1:0] v);
		clamp_bin = (v > STEP_W'(TOP_BIN)) ? BIN_TOP : v[BIN_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/collatz_stopping_time_histogram.sv]
`default_nettype none
// channel | direction | accepted when          | contents
// s_*     | in        | s_tvalid && s_tready  | tuser: cmd; tdata: start_value, bin_index
// m_*     | out       | m_tvalid && m_tready  | tdata: step_count, bin_number, bin_total,
//         |           |                       |        overflow
// process: the idle state takes the transaction, the iteration state runs one collatz step
//   per cycle until it sees the end, then bin read, update and result load
// read bin: read, update and result load; unused command: result load only; clear: all bins cleared, then a result
// after reset a clearing pass over all 1001 bins runs before the first item is taken
// a waiting result sits in the output register, so the next item can be taken
//   while m_tready is low; only the hand-off of a second result waits for it

`include "collatz_stopping_time_histogram_defines.svh"

module collatz_stopping_time_histogram
	import csth_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,  // start_value[63:0], bin_index[73:64], zero
	input  wire logic [CMD_W-1:0]      s_tuser,  // cmd[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_DATA_W-1:0]        m_tdata   // step_count[15:0], bin_number[25:16],
	                                             // bin_total[89:26], overflow[90], zero
);

	state_t state_q, state_d;

	cmd_t                   cmd_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [STEP_W-1:0]      steps_q;
	logic                   ovf_q;
	logic [BIN_W-1:0]       idx_q;
	logic [BIN_W-1:0]       bin_q;
	logic [CNT_W-1:0]       total_q;
	logic [BIN_W-1:0]       clr_cnt_q;
	logic                   clr_reply_q;
	logic [M_DATA_W-1:0]    out_data_q;
	logic                   m_tvalid_q;

	logic [CNT_W-1:0] hist_mem [HIST_DEPTH];
	logic [CNT_W-1:0] rd_data_q;

	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic                   mem_we;
	logic [BIN_W-1:0]       wr_addr;
	logic [CNT_W-1:0]       wr_data;
	logic [BIN_W-1:0]       rd_addr;
	logic [VALUE_WIDTH+1:0] trip;
	logic                   trip_ovf;
	logic                   iter_stop;
	logic                   is_odd;
	logic [START_W-1:0]     in_start;
	logic [BIN_W-1:0]       in_idx;
	cmd_t                   in_cmd;
	logic                   bin_full;
	logic [CNT_W-1:0]       bin_next;
	logic                   in_iter;
	logic                   upd_we;
	logic                   out_ovf;
	logic [BIN_W-1:0]       out_bin;
	logic [STEP_W-1:0]      out_steps;

	assign in_start = s_tdata[START_W-1:0];
	assign in_idx   = s_tdata[START_W+BIN_W-1:START_W];
	assign in_cmd   = cmd_t'(s_tuser);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// 3n+1 computed as n + 2n + 1, two guard bits catch a result past the width
	assign trip     = {2'b00, val_q} + {1'b0, val_q, 1'b0} + (VALUE_WIDTH+2)'(1);
	assign trip_ovf = trip[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b00;
	assign is_odd   = val_q[0];
	assign iter_stop = (val_q == VALUE_WIDTH'(1)) || (steps_q == STEP_MAX);

	assign rd_addr  = (cmd_q == CMD_READ) ? idx_q : clamp_bin(steps_q);
	assign bin_full = rd_data_q == CNT_MAX;
	// a read leaves the count as it is
	assign bin_next = (cmd_q == CMD_PROC && !ovf_q && !bin_full) ?
		rd_data_q + CNT_W'(1) : rd_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == BIN_TOP) begin
					state_d = clr_reply_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_PROC:  state_d = (in_start > START_W'(1)) ? ST_ITER : ST_READ;
						CMD_READ:  state_d = ST_READ;
						CMD_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_ITER: begin
				if (iter_stop || (is_odd && trip_ovf)) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		wr_addr  = bin_q;
		wr_data  = bin_next;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
			end
			ST_IDLE:   s_tready = 1'b1;
			ST_UPDATE: mem_we = (cmd_q == CMD_PROC) && !ovf_q && !bin_full;
			ST_DONE:   out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= (clr_cnt_q == BIN_TOP) ? '0 : clr_cnt_q + BIN_W'(1);
			end
			if (accept) begin
				clr_reply_q <= in_cmd == CMD_CLEAR;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= in_cmd;
			val_q   <= VALUE_WIDTH'(in_start);
			steps_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= clamp_bin(STEP_W'(in_idx));
		end
		if (state_q == ST_ITER && !iter_stop) begin
			if (!is_odd) begin
				val_q   <= val_q >> 1;
				steps_q <= steps_q + STEP_W'(1);
			end else if (trip_ovf) begin
				ovf_q <= 1'b1;
			end else begin
				val_q   <= trip[VALUE_WIDTH-1:0];
				steps_q <= steps_q + STEP_W'(1);
			end
		end
		if (state_q == ST_READ) begin
			bin_q <= rd_addr;
		end
		if (state_q == ST_UPDATE) begin
			total_q <= bin_next;
		end
		if (out_load) begin
			if (cmd_q == CMD_PROC || cmd_q == CMD_READ) begin
				out_data_q <= {5'b0, ovf_q, total_q, bin_q, steps_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	// histogram memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= hist_mem[rd_addr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	assign in_iter   = state_q == ST_ITER;
	assign upd_we    = mem_we && state_q == ST_UPDATE;
	assign out_ovf   = out_data_q[90];
	assign out_bin   = out_data_q[25:16];
	assign out_steps = out_data_q[15:0];

	`CSTH_ASSERT_NOW(a_iter_nonzero, clk, arst_n, in_iter, val_q != '0, "zero value in iteration")
	`CSTH_ASSERT_NOW(a_update_write, clk, arst_n, upd_we, cmd_q == CMD_PROC && !ovf_q, "bad bin write")
	`CSTH_ASSERT_NOW(a_bin_range, clk, arst_n, m_tvalid_q, out_bin <= BIN_TOP, "bin beyond top bin")
	`CSTH_ASSERT_NOW(a_ovf_steps, clk, arst_n, m_tvalid_q && out_ovf, out_steps != STEP_MAX, "ovf at max")
	`CSTH_ASSERT_NEXT(a_load_valid, clk, arst_n, out_load, m_tvalid_q, "result not presented")

endmodule

`default_nettype wire
